/* hdl/vsmf_pkg.sv */
// shared constants, types and register codes for the vertex split max flow block
package vsmf_pkg;

  localparam int MAX_ROOMS = 256;
  localparam int MAX_LINKS = 1024;
  localparam int NODE_CAP  = 2 * MAX_ROOMS;
  localparam int EDGE_CAP  = 2 * MAX_ROOMS + 4 * MAX_LINKS;

  localparam int ROOM_W  = $clog2(MAX_ROOMS);
  localparam int NROOM_W = ROOM_W + 1;
  localparam int NODE_W  = $clog2(NODE_CAP);
  localparam int QPTR_W  = NODE_W + 1;
  localparam int EDGE_W  = $clog2(EDGE_CAP);
  localparam int LINK_AW = $clog2(MAX_LINKS);
  localparam int CNT_W   = LINK_AW + 1;
  localparam int ANT_W   = 16;
  localparam int RES_W   = ANT_W + 1;
  localparam int FLOW_W  = 11;
  localparam int TOT_W   = FLOW_W + 1;
  localparam int PADDR_W = 4;

  localparam logic [EDGE_W-1:0] EDGE_NIL = '1;
  localparam logic [RES_W-1:0]  PF_INIT  = '1;
  localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

  typedef enum logic [1:0] {
    REG_NUM_ROOMS  = 2'd0,
    REG_START_ROOM = 2'd1,
    REG_END_ROOM   = 2'd2,
    REG_ANT_COUNT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [NROOM_W-1:0] num_rooms;
    logic [ROOM_W-1:0]  start_room;
    logic [ROOM_W-1:0]  end_room;
    logic [ANT_W-1:0]   ant_count;
  } cfg_t;

endpackage

/* hdl/vsmf_cfg.sv */
// configuration registers behind the apb port
module vsmf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsmf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output vsmf_pkg::cfg_t                cfg,
  output logic [vsmf_pkg::NROOM_W-1:0]  rooms
);
  import vsmf_pkg::*;

  reg_idx_t sel;
  logic     wr;

  assign sel = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_rooms  <= NROOM_W'(2);
      cfg.start_room <= '0;
      cfg.end_room   <= ROOM_W'(1);
      cfg.ant_count  <= ANT_W'(1);
    end else if (wr) begin
      unique case (sel)
        REG_NUM_ROOMS:  cfg.num_rooms  <= pwdata[NROOM_W-1:0];
        REG_START_ROOM: cfg.start_room <= pwdata[ROOM_W-1:0];
        REG_END_ROOM:   cfg.end_room   <= pwdata[ROOM_W-1:0];
        REG_ANT_COUNT:  cfg.ant_count  <= pwdata[ANT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_NUM_ROOMS:  prdata = 32'(cfg.num_rooms);
      REG_START_ROOM: prdata = 32'(cfg.start_room);
      REG_END_ROOM:   prdata = 32'(cfg.end_room);
      REG_ANT_COUNT:  prdata = 32'(cfg.ant_count);
      default:        prdata = '0;
    endcase
  end

  // room count clamped to the store size
  assign rooms = (cfg.num_rooms > NROOM_W'(MAX_ROOMS)) ? NROOM_W'(MAX_ROOMS) : cfg.num_rooms;

endmodule

/* hdl/vsmf_links.sv */
// link store with fill count and drop flag
module vsmf_links (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [vsmf_pkg::ROOM_W-1:0]   room_a,
  input  logic [vsmf_pkg::ROOM_W-1:0]   room_b,
  input  logic [vsmf_pkg::NROOM_W-1:0]  rooms,
  input  logic [vsmf_pkg::LINK_AW-1:0]  rd_addr,
  output logic [2*vsmf_pkg::ROOM_W-1:0] rd_data,
  input  logic                          clr,
  output logic [vsmf_pkg::CNT_W-1:0]    count,
  output logic                          dropped
);
  import vsmf_pkg::*;

  logic [2*ROOM_W-1:0] store [MAX_LINKS];
  logic                keep;

  assign keep = (count < CNT_W'(MAX_LINKS)) && ({1'b0, room_a} < rooms) &&
                ({1'b0, room_b} < rooms);

  always_ff @(posedge clk) begin
    if (load && keep) begin
      store[count[LINK_AW-1:0]] <= {room_a, room_b};
    end
    rd_data <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (load) begin
      if (keep) begin
        count <= count + CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

endmodule

/* hdl/vsmf_flow.sv */
// graph builder and augmenting path sequencer with its memories
module vsmf_flow (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  vsmf_pkg::cfg_t                cfg,
  input  logic [vsmf_pkg::NROOM_W-1:0]  rooms,
  input  logic [vsmf_pkg::CNT_W-1:0]    link_count,
  input  logic                          link_dropped,
  output logic [vsmf_pkg::LINK_AW-1:0]  link_addr,
  input  logic [2*vsmf_pkg::ROOM_W-1:0] link_data,
  output logic                          link_clr,
  output logic                          busy,
  output logic                          done,
  output logic [vsmf_pkg::FLOW_W-1:0]   flow_value,
  output logic                          status
);
  import vsmf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR_HEAD, S_SPLIT, S_LINK_RD, S_LINK_CHK, S_ARC0, S_ARC1, S_ARC2,
    S_VIS_CLR, S_BFS_INIT, S_BFS_POP, S_BFS_NODE, S_BFS_HEAD, S_BFS_EDGE, S_BFS_VIS,
    S_BFS_TEST, S_AUG_START, S_AUG_PAR, S_AUG_E, S_AUG_R1, S_AUG_R2, S_FINISH
  } state_t;

  typedef enum logic [1:0] {RET_SPLIT, RET_LINK1, RET_LINK2} ret_t;

  state_t state;
  ret_t   arc_ret;

  logic [QPTR_W-1:0] idx;
  logic [CNT_W-1:0]  k;
  logic [EDGE_W-1:0] e_cnt, cur_e, cur_nxt;
  logic [NODE_W-1:0] arc_u, arc_v, cur_v;
  logic [RES_W-1:0]  arc_cap, cur_res, pf;
  logic [ROOM_W-1:0] la, lb;
  logic [QPTR_W-1:0] qh, qt;
  logic [TOT_W-1:0]  total;
  logic              bdrop, pass;

  // memories
  logic [EDGE_W-1:0] head_mem [NODE_CAP];
  logic [EDGE_W-1:0] nxt_mem  [EDGE_CAP];
  logic [NODE_W-1:0] tgt_mem  [EDGE_CAP];
  logic [RES_W-1:0]  res_mem  [EDGE_CAP];
  logic [NODE_W-1:0] q_mem    [NODE_CAP];
  logic              vis_mem  [NODE_CAP];
  logic [EDGE_W-1:0] par_mem  [NODE_CAP];

  logic              head_we, arc_we, res_we, q_we, vis_we, par_we, vis_wd;
  logic [NODE_W-1:0] head_wa, head_ra, q_wa, q_ra, vis_wa, vis_ra, par_wa, par_ra;
  logic [NODE_W-1:0] tgt_wd, q_wd;
  logic [EDGE_W-1:0] head_wd, arc_wa, nxt_wd, res_wa, e_ra, tgt_ra, par_wd;
  logic [RES_W-1:0]  res_wd;
  logic [EDGE_W-1:0] head_rd, nxt_rd, par_rd;
  logic [NODE_W-1:0] tgt_rd, q_rd;
  logic [RES_W-1:0]  res_rd;
  logic              vis_rd;

  logic [NODE_W-1:0]  src, snk;
  logic [ROOM_W-1:0]  la_in, lb_in;
  logic               bad_term;
  logic [TOT_W+5:0]   sum;

  assign src      = {cfg.start_room, 1'b1};
  assign snk      = {cfg.end_room, 1'b0};
  assign bad_term = ({1'b0, cfg.start_room} >= rooms) || ({1'b0, cfg.end_room} >= rooms);
  assign la_in    = link_data[2*ROOM_W-1:ROOM_W];
  assign lb_in    = link_data[ROOM_W-1:0];
  assign sum      = (TOT_W+6)'(total) + (TOT_W+6)'(pf);
  assign busy     = (state != S_IDLE);
  assign link_clr = (state == S_FINISH);
  assign link_addr = k[LINK_AW-1:0];

  always_comb begin
    head_we = 1'b0; head_wa = arc_u; head_wd = e_cnt; head_ra = arc_u;
    arc_we  = 1'b0; arc_wa = e_cnt; nxt_wd = head_rd; tgt_wd = arc_v;
    res_we  = 1'b0; res_wa = e_cnt; res_wd = arc_cap;
    e_ra    = cur_e; tgt_ra = cur_e;
    q_we    = 1'b0; q_wa = qt[NODE_W-1:0]; q_wd = cur_v; q_ra = qh[NODE_W-1:0];
    vis_we  = 1'b0; vis_wa = cur_v; vis_wd = 1'b1; vis_ra = tgt_rd;
    par_we  = 1'b0; par_wa = cur_v; par_wd = cur_e; par_ra = cur_v;
    unique case (state)
      S_CLR_HEAD: begin
        head_we = 1'b1; head_wa = idx[NODE_W-1:0]; head_wd = EDGE_NIL;
      end
      S_ARC1: begin
        head_we = 1'b1; head_wa = arc_u; head_wd = e_cnt; head_ra = arc_v;
        arc_we = 1'b1; res_we = 1'b1;
      end
      S_ARC2: begin
        head_we = 1'b1; head_wa = arc_v; head_wd = {e_cnt[EDGE_W-1:1], 1'b1};
        arc_we = 1'b1; arc_wa = {e_cnt[EDGE_W-1:1], 1'b1}; tgt_wd = arc_u;
        res_we = 1'b1; res_wa = {e_cnt[EDGE_W-1:1], 1'b1}; res_wd = '0;
      end
      S_VIS_CLR: begin
        vis_we = 1'b1; vis_wa = idx[NODE_W-1:0]; vis_wd = 1'b0;
      end
      S_BFS_INIT: begin
        q_we = 1'b1; q_wa = '0; q_wd = src;
        vis_we = 1'b1; vis_wa = src;
      end
      S_BFS_NODE: head_ra = q_rd;
      S_BFS_TEST: begin
        if (!vis_rd && cur_res != '0) begin
          vis_we = 1'b1; par_we = 1'b1; q_we = 1'b1;
        end
      end
      S_AUG_E: begin
        e_ra = par_rd; tgt_ra = {par_rd[EDGE_W-1:1], ~par_rd[0]};
      end
      S_AUG_R1: begin
        if (pass) begin
          res_we = 1'b1; res_wa = cur_e; res_wd = res_rd - pf;
          e_ra = {cur_e[EDGE_W-1:1], ~cur_e[0]};
        end
      end
      S_AUG_R2: begin
        res_we = 1'b1; res_wa = {cur_e[EDGE_W-1:1], ~cur_e[0]}; res_wd = res_rd + pf;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (arc_we) begin
      nxt_mem[arc_wa] <= nxt_wd;
      tgt_mem[arc_wa] <= tgt_wd;
    end
    nxt_rd <= nxt_mem[e_ra];
    tgt_rd <= tgt_mem[tgt_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    res_rd <= res_mem[e_ra];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_wa] <= q_wd;
    q_rd <= q_mem[q_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[par_wa] <= par_wd;
    par_rd <= par_mem[par_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (go) begin
            idx   <= '0;
            total <= '0;
            bdrop <= 1'b0;
            state <= S_CLR_HEAD;
          end
        end
        S_CLR_HEAD: begin
          idx <= idx + QPTR_W'(1);
          if (idx == QPTR_W'(NODE_CAP - 1)) begin
            idx   <= '0;
            e_cnt <= '0;
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          if (idx < QPTR_W'(rooms)) begin
            arc_u   <= {idx[ROOM_W-1:0], 1'b0};
            arc_v   <= {idx[ROOM_W-1:0], 1'b1};
            arc_cap <= (idx[ROOM_W-1:0] == cfg.start_room || idx[ROOM_W-1:0] == cfg.end_room)
                       ? RES_W'(cfg.ant_count) : RES_W'(1);
            arc_ret <= RET_SPLIT;
            state   <= S_ARC0;
          end else begin
            k     <= '0;
            state <= S_LINK_RD;
          end
        end
        S_LINK_RD: begin
          if (k < link_count) begin
            state <= S_LINK_CHK;
          end else if (bad_term) begin
            state <= S_FINISH;
          end else begin
            idx   <= '0;
            state <= S_VIS_CLR;
          end
        end
        S_LINK_CHK: begin
          if ({1'b0, la_in} < rooms && {1'b0, lb_in} < rooms) begin
            la      <= la_in;
            lb      <= lb_in;
            arc_u   <= {la_in, 1'b1};
            arc_v   <= {lb_in, 1'b0};
            arc_cap <= RES_W'(1);
            arc_ret <= RET_LINK1;
            state   <= S_ARC0;
          end else begin
            bdrop <= 1'b1;
            k     <= k + CNT_W'(1);
            state <= S_LINK_RD;
          end
        end
        S_ARC0: state <= S_ARC1;
        S_ARC1: state <= S_ARC2;
        S_ARC2: begin
          e_cnt <= e_cnt + EDGE_W'(2);
          unique case (arc_ret)
            RET_SPLIT: begin
              idx   <= idx + QPTR_W'(1);
              state <= S_SPLIT;
            end
            RET_LINK1: begin
              arc_u   <= {lb, 1'b1};
              arc_v   <= {la, 1'b0};
              arc_ret <= RET_LINK2;
              state   <= S_ARC0;
            end
            default: begin
              k     <= k + CNT_W'(1);
              state <= S_LINK_RD;
            end
          endcase
        end
        S_VIS_CLR: begin
          idx <= idx + QPTR_W'(1);
          if (idx == QPTR_W'(NODE_CAP - 1)) state <= S_BFS_INIT;
        end
        S_BFS_INIT: begin
          qh    <= '0;
          qt    <= QPTR_W'(1);
          state <= S_BFS_POP;
        end
        S_BFS_POP: begin
          if (qh == qt) begin
            state <= S_FINISH;
          end else begin
            qh    <= qh + QPTR_W'(1);
            state <= S_BFS_NODE;
          end
        end
        S_BFS_NODE: state <= (q_rd == snk) ? S_AUG_START : S_BFS_HEAD;
        S_BFS_HEAD: begin
          cur_e <= head_rd;
          state <= S_BFS_EDGE;
        end
        S_BFS_EDGE: state <= (cur_e == EDGE_NIL) ? S_BFS_POP : S_BFS_VIS;
        S_BFS_VIS: begin
          cur_v   <= tgt_rd;
          cur_res <= res_rd;
          cur_nxt <= nxt_rd;
          state   <= S_BFS_TEST;
        end
        S_BFS_TEST: begin
          if (!vis_rd && cur_res != '0) qt <= qt + QPTR_W'(1);
          cur_e <= cur_nxt;
          state <= S_BFS_EDGE;
        end
        S_AUG_START: begin
          pf    <= PF_INIT;
          cur_v <= snk;
          pass  <= 1'b0;
          state <= S_AUG_PAR;
        end
        S_AUG_PAR: begin
          if (cur_v == src) begin
            if (!pass) begin
              pass  <= 1'b1;
              cur_v <= snk;
            end else begin
              // saturate one above the largest reportable flow
              total <= (sum > (TOT_W+6)'(FLOW_MAX)) ? TOT_W'(FLOW_MAX) + TOT_W'(1)
                                                     : sum[TOT_W-1:0];
              idx   <= '0;
              state <= S_VIS_CLR;
            end
          end else begin
            state <= S_AUG_E;
          end
        end
        S_AUG_E: begin
          cur_e <= par_rd;
          state <= S_AUG_R1;
        end
        S_AUG_R1: begin
          cur_v <= tgt_rd;
          if (!pass) begin
            if (res_rd < pf) pf <= res_rd;
            state <= S_AUG_PAR;
          end else begin
            state <= S_AUG_R2;
          end
        end
        S_AUG_R2: state <= S_AUG_PAR;
        S_FINISH: begin
          done       <= 1'b1;
          flow_value <= bad_term ? '0 :
                        (total > TOT_W'(FLOW_MAX)) ? FLOW_MAX : total[FLOW_W-1:0];
          status     <= link_dropped || bdrop;
          state      <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hdl/vertex_split_max_flow.sv */
// top level: apb registers, link store and max flow sequencer
// a load word leaves busy low, so loads can follow back to back
// a run word holds busy high while it clears the heads, splits each room and adds each kept link,
// then runs searches that clear the visited marks, pop nodes, scan arcs and augment along each path;
// done is high for the first cycle with busy low; the receiver cannot stall
// synchronous reset clears the config registers, state, link count and drop flag; memories need no clearing
module vertex_split_max_flow (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          req_type,
  input  logic [vsmf_pkg::ROOM_W-1:0]   room_a,
  input  logic [vsmf_pkg::ROOM_W-1:0]   room_b,
  output logic                          done,
  output logic [vsmf_pkg::FLOW_W-1:0]   flow_value,
  output logic                          status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vsmf_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import vsmf_pkg::*;

  cfg_t                cfg;
  logic [NROOM_W-1:0]  rooms;
  logic [LINK_AW-1:0]  link_addr;
  logic [2*ROOM_W-1:0] link_data;
  logic [CNT_W-1:0]    link_count;
  logic                link_dropped, link_clr, accept;

  assign pready = 1'b1;
  assign accept = start && !busy;

  vsmf_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .cfg(cfg), .rooms(rooms)
  );

  vsmf_links u_links (
    .clk(clk), .rst(rst), .load(accept && !req_type), .room_a(room_a), .room_b(room_b),
    .rooms(rooms), .rd_addr(link_addr), .rd_data(link_data), .clr(link_clr),
    .count(link_count), .dropped(link_dropped)
  );

  vsmf_flow u_flow (
    .clk(clk), .rst(rst), .go(accept && req_type), .cfg(cfg), .rooms(rooms),
    .link_count(link_count), .link_dropped(link_dropped), .link_addr(link_addr),
    .link_data(link_data), .link_clr(link_clr), .busy(busy), .done(done),
    .flow_value(flow_value), .status(status)
  );

endmodule

/* hdl/vsmf_checker.sv */
// port level checks for the max flow block, bound to the top level
module vsmf_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic req_type,
  input logic done,
  input logic pready
);

  // a run word makes the block busy next cycle
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type |=> busy) else $error("run word did not raise busy");

  // a load word never blocks the next word
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !req_type |=> !busy) else $error("load word raised busy");

  // a result word only shows once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $fell(busy)) else $error("result word while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe held");

  a_pready: assert property (@(posedge clk) pready) else $error("pready low");

endmodule

bind vertex_split_max_flow vsmf_checker u_vsmf_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
  .done(done), .pready(pready)
);

/* verif/vertex_split_max_flow_tb.sv */
// testbench for vertex_split_max_flow: directed table, random link batches, max flow predictor
module vertex_split_max_flow_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vsmf_pkg::*;

  localparam int PATH_CAP = 1000000;
  localparam int ITEM_GOAL = 1550;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic req_type = 1'b0;
  logic [ROOM_W-1:0] room_a = '0;
  logic [ROOM_W-1:0] room_b = '0;
  logic done;
  logic [FLOW_W-1:0] flow_value;
  logic status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  vertex_split_max_flow u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req_type(req_type),
    .room_a(room_a), .room_b(room_b), .done(done), .flow_value(flow_value),
    .status(status), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  typedef struct {
    logic [FLOW_W-1:0] flow;
    logic              dropped;
  } flow_word_t;

  typedef struct {
    bit       is_cfg;
    reg_idx_t idx;
    int       val;
    bit       req;
    int       a;
    int       b;
    bit       typed;
    int       flow;
    bit       dropped;
  } row_t;

  flow_word_t pending_flows[$];
  int errors = 0;
  int items_sent = 0;

  // predictor state
  int rooms_cfg = 2, src_room = 0, snk_room = 1, ant_cap = 1;
  logic [15:0] link_mem [MAX_LINKS];
  int link_cnt = 0;
  bit link_dropped = 0;
  int arc_to [EDGE_CAP];
  int arc_res [EDGE_CAP];
  int arc_twin [EDGE_CAP];
  int node_first [NODE_CAP+1];
  int node_fill [NODE_CAP];
  int bfs_q [NODE_CAP];
  int came_by [NODE_CAP];
  bit seen [NODE_CAP];

  function automatic int rooms_live();
    return rooms_cfg > MAX_ROOMS ? MAX_ROOMS : rooms_cfg;
  endfunction

  function automatic void add_arc(int u, int v, int cap);
    int e, r;
    e = node_fill[u]++;
    r = node_fill[v]++;
    arc_to[e] = v; arc_res[e] = cap; arc_twin[e] = r;
    arc_to[r] = u; arc_res[r] = 0;   arc_twin[r] = e;
  endfunction

  function automatic void store_link(int a, int b);
    int rooms;
    rooms = rooms_live();
    if (link_cnt >= MAX_LINKS || a >= rooms || b >= rooms) begin
      link_dropped = 1;
    end else begin
      link_mem[link_cnt] = {a[7:0], b[7:0]};
      link_cnt++;
    end
  endfunction

  function automatic bit find_path(int nodes, int src, int snk);
    int head, tail, u, v;
    head = 0;
    tail = 0;
    for (int i = 0; i < NODE_CAP; i++) seen[i] = 0;
    bfs_q[tail++] = src;
    seen[src] = 1;
    while (head < tail) begin
      u = bfs_q[head++];
      if (u == snk) return 1;
      for (int e = node_first[u]; e < node_first[u+1]; e++) begin
        v = arc_to[e];
        if (v < nodes && !seen[v] && arc_res[e] > 0 && tail < NODE_CAP) begin
          seen[v] = 1;
          came_by[v] = e;
          bfs_q[tail++] = v;
        end
      end
    end
    return 0;
  endfunction

  function automatic int predict_flow();
    int rooms, nodes, sum, d, a, b, src, snk, total, pf, v, e;
    rooms = rooms_live();
    nodes = 2 * rooms;
    for (int i = 0; i <= NODE_CAP; i++) node_first[i] = 0;
    for (int i = 0; i < rooms; i++) begin
      node_first[2*i]++;
      node_first[2*i+1]++;
    end
    for (int k = 0; k < link_cnt; k++) begin
      a = link_mem[k][15:8];
      b = link_mem[k][7:0];
      if (a >= rooms || b >= rooms) begin
        link_dropped = 1;
      end else begin
        node_first[2*a+1]++; node_first[2*b]++;
        node_first[2*b+1]++; node_first[2*a]++;
      end
    end
    sum = 0;
    for (int i = 0; i <= nodes; i++) begin
      d = node_first[i];
      node_first[i] = sum;
      if (i < nodes) node_fill[i] = sum;
      sum += d;
    end
    for (int i = 0; i < rooms; i++)
      add_arc(2*i, 2*i+1, (i == src_room || i == snk_room) ? ant_cap : 1);
    for (int k = 0; k < link_cnt; k++) begin
      a = link_mem[k][15:8];
      b = link_mem[k][7:0];
      if (a < rooms && b < rooms) begin
        add_arc(2*a+1, 2*b, 1);
        add_arc(2*b+1, 2*a, 1);
      end
    end
    if (src_room >= rooms || snk_room >= rooms) return 0;
    src = 2*src_room + 1;
    snk = 2*snk_room;
    total = 0;
    while (find_path(nodes, src, snk)) begin
      pf = PATH_CAP;
      v = snk;
      while (v != src) begin
        e = came_by[v];
        if (arc_res[e] < pf) pf = arc_res[e];
        v = arc_to[arc_twin[e]];
      end
      v = snk;
      while (v != src) begin
        e = came_by[v];
        arc_res[e] -= pf;
        arc_res[arc_twin[e]] += pf;
        v = arc_to[arc_twin[e]];
      end
      total += pf;
      if (total > FLOW_MAX) total = FLOW_MAX + 1;
    end
    return total > FLOW_MAX ? FLOW_MAX : total;
  endfunction

  // one word to the block; a run pushes the typed or predicted result
  task automatic send_word(bit req, int a, int b, bit typed = 0, int tflow = 0,
                           bit tdrop = 0);
    flow_word_t w;
    @(negedge clk);
    start <= 1'b1;
    req_type <= req;
    room_a <= a[7:0];
    room_b <= b[7:0];
    do @(posedge clk); while (busy);
    items_sent++;
    if (!req) begin
      store_link(a, b);
    end else begin
      w.flow = FLOW_W'(predict_flow());
      w.dropped = link_dropped;
      link_cnt = 0;
      link_dropped = 0;
      if (typed) begin
        w.flow = FLOW_W'(tflow);
        w.dropped = tdrop;
      end
      pending_flows.push_back(w);
    end
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_flows.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t idx, int val);
    logic [31:0] mask;
    case (idx)
      REG_NUM_ROOMS:  begin rooms_cfg = val & 'h1FF;  mask = 'h1FF;  end
      REG_START_ROOM: begin src_room  = val & 'hFF;   mask = 'hFF;   end
      REG_END_ROOM:   begin snk_room  = val & 'hFF;   mask = 'hFF;   end
      default:        begin ant_cap   = val & 'hFFFF; mask = 'hFFFF; end
    endcase
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(4 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if ((prdata & mask) !== (val & mask)) begin
      $display("%0t reg %0d readback exp %0h got %0h", $time, idx, val & mask, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    flow_word_t w;
    if (!rst && done) begin
      if (pending_flows.size() == 0) begin
        $display("%0t unexpected flow word %0d/%0b", $time, flow_value, status);
        errors++;
      end else begin
        w = pending_flows.pop_front();
        if (flow_value !== w.flow) begin
          $display("%0t flow_value exp %0d got %0d", $time, w.flow, flow_value);
          errors++;
        end
        if (status !== w.dropped) begin
          $display("%0t status exp %0b got %0b", $time, w.dropped, status);
          errors++;
        end
      end
    end
  end

  function automatic row_t cfg_row(reg_idx_t idx, int val);
    row_t r;
    r = '{idx: REG_NUM_ROOMS, default: 0};
    r.is_cfg = 1; r.idx = idx; r.val = val;
    return r;
  endfunction

  function automatic row_t word_row(bit req, int a, int b, bit typed = 0, int f = 0,
                                    bit d = 0);
    row_t r;
    r = '{idx: REG_NUM_ROOMS, default: 0};
    r.req = req; r.a = a; r.b = b; r.typed = typed; r.flow = f; r.dropped = d;
    return r;
  endfunction

  initial begin
    row_t rows[$];
    int burst, rooms, nlinks, nruns, ra, rb;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset values, drops, bad terminals, shrunk rooms, same start and end
    rows.push_back(word_row(1, 0, 0, 1, 0, 0));
    rows.push_back(word_row(0, 0, 1));
    rows.push_back(word_row(1, 0, 0, 1, 1, 0));
    rows.push_back(word_row(0, 2, 0));
    rows.push_back(word_row(1, 0, 0, 1, 0, 1));
    rows.push_back(cfg_row(REG_NUM_ROOMS, 8));
    rows.push_back(cfg_row(REG_ANT_COUNT, 2));
    rows.push_back(word_row(0, 0, 2));
    rows.push_back(word_row(0, 2, 1));
    rows.push_back(word_row(0, 0, 3));
    rows.push_back(word_row(0, 3, 1));
    rows.push_back(word_row(0, 0, 1));
    rows.push_back(word_row(1, 0, 0));
    rows.push_back(word_row(0, 4, 5));
    rows.push_back(word_row(0, 7, 1));
    rows.push_back(cfg_row(REG_NUM_ROOMS, 4));
    rows.push_back(word_row(1, 0, 0));
    rows.push_back(cfg_row(REG_START_ROOM, 255));
    rows.push_back(word_row(1, 0, 0, 1, 0, 0));
    rows.push_back(cfg_row(REG_NUM_ROOMS, 0));
    rows.push_back(word_row(1, 0, 0, 1, 0, 0));
    rows.push_back(cfg_row(REG_NUM_ROOMS, 256));
    rows.push_back(cfg_row(REG_START_ROOM, 3));
    rows.push_back(cfg_row(REG_END_ROOM, 3));
    rows.push_back(cfg_row(REG_ANT_COUNT, 65535));
    rows.push_back(word_row(0, 3, 3));
    rows.push_back(word_row(0, 255, 255));
    rows.push_back(word_row(0, 3, 128));
    rows.push_back(word_row(0, 128, 3));
    rows.push_back(word_row(1, 0, 0));
    rows.push_back(cfg_row(REG_NUM_ROOMS, 511));
    rows.push_back(cfg_row(REG_END_ROOM, 255));
    rows.push_back(cfg_row(REG_ANT_COUNT, 0));
    rows.push_back(word_row(0, 255, 0));
    rows.push_back(word_row(0, 3, 255));
    rows.push_back(word_row(1, 0, 0));
    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        settle();
        reg_write(rows[i].idx, rows[i].val);
      end else begin
        send_word(rows[i].req, rows[i].a, rows[i].b, rows[i].typed, rows[i].flow,
                  rows[i].dropped);
      end
    end

    // store full: a few parallel links between the terminals, the rest self links
    settle();
    reg_write(REG_NUM_ROOMS, 2);
    reg_write(REG_START_ROOM, 0);
    reg_write(REG_END_ROOM, 1);
    reg_write(REG_ANT_COUNT, 65535);
    for (int k = 0; k < MAX_LINKS + 6; k++) begin
      if (k % 97 == 0) send_word(0, 0, 1);
      else send_word(0, k & 1, k & 1);
    end
    send_word(1, 0, 0);

    // random batches: mostly small graphs with in-range links
    burst = $urandom_range(1, 20);
    while (items_sent < ITEM_GOAL) begin
      settle();
      case ($urandom_range(0, 9))
        0: rooms = 256;
        1: rooms = $urandom_range(257, 511);
        2: rooms = $urandom_range(0, 1);
        default: rooms = $urandom_range(2, 12);
      endcase
      reg_write(REG_NUM_ROOMS, rooms);
      if (rooms > 256) rooms = 256;
      ra = (rooms > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, rooms - 1)
                                                     : $urandom_range(0, 255);
      rb = (rooms > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, rooms - 1)
                                                     : $urandom_range(0, 255);
      reg_write(REG_START_ROOM, ra);
      reg_write(REG_END_ROOM, rb);
      reg_write(REG_ANT_COUNT, $urandom_range(0, 5) == 0 ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 4));
      nruns = $urandom_range(1, 4);
      repeat (nruns) begin
        nlinks = $urandom_range(0, rooms == 256 ? 300 : 30);
        // keep the total close to the item goal
        if (nlinks > ITEM_GOAL - items_sent) nlinks = ITEM_GOAL - items_sent;
        if (nlinks < 0) nlinks = 0;
        repeat (nlinks) begin
          if (rooms > 0 && $urandom_range(0, 15) != 0) begin
            ra = $urandom_range(0, rooms - 1);
            rb = $urandom_range(0, rooms - 1);
          end else begin
            ra = $urandom_range(0, 255);
            rb = $urandom_range(0, 255);
          end
          send_word(0, ra, rb);
          if (--burst == 0) begin
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 9));
            burst = $urandom_range(1, 20);
          end
        end
        send_word(1, $urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    settle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("vertex_split_max_flow_tb: done, clean");
    end else begin
      $display("vertex_split_max_flow_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("vertex_split_max_flow_tb: done, errors");
    $finish;
  end

endmodule

/* sim.f */
hdl/vsmf_pkg.sv
hdl/vsmf_cfg.sv
hdl/vsmf_links.sv
hdl/vsmf_flow.sv
hdl/vertex_split_max_flow.sv
hdl/vsmf_checker.sv
verif/vertex_split_max_flow_tb.sv
